// ===== hdl/lcr_pkg.sv =====
// Shared types and constants for the load-cell converter serial reader.
package lcr_pkg;

  localparam int WORD_BITS   = 24;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_BIT     = 2'd0,
    CMD_CAPTURE = 2'd1,
    CMD_LOAD    = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    GAIN_A128 = 2'd0,
    GAIN_A64  = 2'd1,
    GAIN_B32  = 2'd2
  } gain_mode_t;

  localparam logic [1:0] PULSES_A128 = 2'd1;
  localparam logic [1:0] PULSES_A64  = 2'd3;
  localparam logic [1:0] PULSES_B32  = 2'd2;

  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_CAPTURE,
    OP_LOAD
  } op_kind_t;

  typedef struct packed {
    op_kind_t                    kind;
    logic signed [WORD_BITS-1:0] value;
  } op_t;

  function automatic logic [1:0] pulses_for(gain_mode_t mode);
    logic [1:0] p;
    unique case (mode)
      GAIN_A64: p = PULSES_A64;
      GAIN_B32: p = PULSES_B32;
      default:  p = PULSES_A128;
    endcase
    return p;
  endfunction

endpackage

// ===== hdl/lcr_queue.sv =====
// Two-entry operation queue between the front and back ends.
module lcr_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  lcr_pkg::op_t push_op,
  output logic         push_ready,
  input  logic         pop,
  output logic         pop_valid,
  output lcr_pkg::op_t pop_op
);

  localparam int PTR_W = (lcr_pkg::QUEUE_DEPTH > 1) ? $clog2(lcr_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(lcr_pkg::QUEUE_DEPTH + 1);

  lcr_pkg::op_t q_mem [lcr_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign push_ready = (count_r != CNT_W'(lcr_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_op     = q_mem[rd_ptr_r];

  function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
    return (p == PTR_W'(lcr_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push && push_ready) q_mem[wr_ptr_r] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push && push_ready) wr_ptr_r <= bump(wr_ptr_r);
      if (pop && pop_valid) rd_ptr_r <= bump(rd_ptr_r);
      case ({push && push_ready, pop && pop_valid})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== hdl/lcr_front.sv =====
// Front end: takes input transactions, assembles data bits, queues operations.
module lcr_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_cmd,
  input  logic                                 in_data_bit,
  input  logic signed [lcr_pkg::WORD_BITS-1:0] in_tare_value,
  output logic                                 push,
  output lcr_pkg::op_t                         push_op,
  input  logic                                 push_ready
);

  localparam int BC_W = $clog2(lcr_pkg::WORD_BITS + 1);

  logic [lcr_pkg::WORD_BITS-1:0] shift_r, shift_nxt;
  logic [BC_W-1:0]               count_r, count_nxt;
  logic                          accept;

  assign in_stall = !push_ready;
  assign accept   = in_valid && push_ready;

  always_comb begin
    shift_nxt     = shift_r;
    count_nxt     = count_r;
    push          = 1'b0;
    push_op.kind  = lcr_pkg::OP_SAMPLE;
    push_op.value = in_tare_value;
    unique case (lcr_pkg::cmd_t'(in_cmd))
      lcr_pkg::CMD_BIT: begin
        shift_nxt = {shift_r[lcr_pkg::WORD_BITS-2:0], in_data_bit};
        count_nxt = count_r + BC_W'(1);
        if (count_r == BC_W'(lcr_pkg::WORD_BITS - 1)) begin
          push          = accept;
          push_op.value = shift_nxt;
          shift_nxt     = '0;
          count_nxt     = '0;
        end
      end
      lcr_pkg::CMD_CAPTURE: begin
        push         = accept;
        push_op.kind = lcr_pkg::OP_CAPTURE;
      end
      lcr_pkg::CMD_LOAD: begin
        push         = accept;
        push_op.kind = lcr_pkg::OP_LOAD;
      end
      default: ;  // reserved command: dropped
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= '0;
      count_r <= '0;
    end else if (accept) begin
      shift_r <= shift_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ===== hdl/lcr_back.sv =====
// Back end: sample window, running sum, serial divider, tare and result register.
module lcr_back #(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 op_valid,
  input  lcr_pkg::op_t                         op,
  output logic                                 op_pop,
  input  lcr_pkg::gain_mode_t                  gain_mode,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [lcr_pkg::WORD_BITS-1:0] out_sample_value,
  output logic signed [lcr_pkg::WORD_BITS-1:0] out_average_value,
  output logic signed [lcr_pkg::WORD_BITS:0]   out_net_sample,
  output logic signed [lcr_pkg::WORD_BITS:0]   out_net_average,
  output logic [1:0]                           out_gain_pulses,
  output logic [$clog2(WINDOW_DEPTH+1)-1:0]    out_window_fill
);

  localparam int W      = lcr_pkg::WORD_BITS;
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SUM_W  = W + FILL_W;
  localparam int STEP_W = $clog2(SUM_W);

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_UPD, ST_ABS, ST_DIV, ST_SIGN, ST_FIN
  } state_t;

  state_t                  state_r;
  logic signed [W-1:0]     win_mem [WINDOW_DEPTH];
  logic signed [W-1:0]     sample_r, old_r, avg_r, tare_r;
  logic [SLOT_W-1:0]       slot_r;
  logic [FILL_W-1:0]       fill_r;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [SUM_W-1:0]        div_r;
  logic [FILL_W-1:0]       rem_r;
  logic [FILL_W:0]         rem_sh;
  logic [STEP_W-1:0]       step_r;
  logic                    neg_r, full, out_free;

  assign op_pop   = (state_r == ST_IDLE) && op_valid;
  assign full     = (fill_r == FILL_W'(WINDOW_DEPTH));
  assign out_free = !out_valid || !out_stall;
  assign rem_sh   = {rem_r, div_r[SUM_W-1]};

  always_comb begin
    sum_nxt = sum_r + SUM_W'(sample_r);
    if (full) sum_nxt = sum_nxt - SUM_W'(old_r);
  end

  // window store: old entry read before the slot is overwritten
  always_ff @(posedge clk) begin
    if (state_r == ST_READ) old_r <= win_mem[slot_r];
    if (state_r == ST_UPD) win_mem[slot_r] <= sample_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      slot_r    <= '0;
      fill_r    <= '0;
      sum_r     <= '0;
      avg_r     <= '0;
      tare_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state_r == ST_FIN && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (op_valid) begin
            case (op.kind)
              lcr_pkg::OP_CAPTURE: tare_r <= avg_r;
              lcr_pkg::OP_LOAD:    tare_r <= op.value;
              default: begin
                sample_r <= op.value;
                state_r  <= ST_READ;
              end
            endcase
          end
        end
        ST_READ: state_r <= ST_UPD;
        ST_UPD: begin
          sum_r <= sum_nxt;
          if (!full) fill_r <= fill_r + FILL_W'(1);
          slot_r  <= (slot_r == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_r + SLOT_W'(1);
          state_r <= ST_ABS;
        end
        ST_ABS: begin
          neg_r   <= sum_r[SUM_W-1];
          div_r   <= sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
          rem_r   <= '0;
          step_r  <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          // restoring division, one quotient bit a cycle
          if (rem_sh >= {1'b0, fill_r}) begin
            rem_r <= FILL_W'(rem_sh - {1'b0, fill_r});
            div_r <= {div_r[SUM_W-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh[FILL_W-1:0];
            div_r <= {div_r[SUM_W-2:0], 1'b0};
          end
          step_r <= step_r + STEP_W'(1);
          if (step_r == STEP_W'(SUM_W - 1)) state_r <= ST_SIGN;
        end
        ST_SIGN: begin
          avg_r   <= neg_r ? -$signed(div_r[W-1:0]) : $signed(div_r[W-1:0]);
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            out_sample_value  <= sample_r;
            out_average_value <= avg_r;
            out_net_sample    <= {sample_r[W-1], sample_r} - {tare_r[W-1], tare_r};
            out_net_average   <= {avg_r[W-1], avg_r} - {tare_r[W-1], tare_r};
            out_gain_pulses   <= lcr_pkg::pulses_for(gain_mode);
            out_window_fill   <= fill_r;
            state_r           <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/load_cell_adc_serial_reader.sv =====
// Top level of the load-cell converter serial reader.
//
// Input channel (in_valid / in_stall): one transaction per converter event.
//   cmd bit shifts in_data_bit into the word, MSB first; the 24th bit
//   completes a sample. cmd capture sets the tare to the current window
//   average, cmd load sets it to in_tare_value. Reserved command: dropped.
// Result channel (out_valid / out_stall): one transaction per completed
//   sample: sample, window average (truncated toward zero), both minus the
//   tare, gain pulses for the next conversion and the window fill.
// Config (cfg_valid / cfg_ready): gain_mode, always ready; code 3 ignored.
//
// Path: a completing bit reaches the result register through the queue,
//   window read and sum update, then the restoring divider over SUM_W =
//   24 + clog2(WINDOW_DEPTH+1) quotient bits, plus sign and output steps.
//   Non-completing bits never reach the back end; tare commands are taken
//   there in its idle state. A sample holds the back end until it is back
//   in idle; the two-entry queue keeps in_stall low while bits arrive at
//   the converter's pace.
// Stall: a held result blocks only the next result; the divider runs on and
//   tares are taken till that result waits; in_stall rises once the queue fills.
// Reset (synchronous, rst_n low): empties window, sum, tare and queue.
module load_cell_adc_serial_reader #(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_cmd,
  input  logic                                 in_data_bit,
  input  logic signed [lcr_pkg::WORD_BITS-1:0] in_tare_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [lcr_pkg::WORD_BITS-1:0] out_sample_value,
  output logic signed [lcr_pkg::WORD_BITS-1:0] out_average_value,
  output logic signed [lcr_pkg::WORD_BITS:0]   out_net_sample,
  output logic signed [lcr_pkg::WORD_BITS:0]   out_net_average,
  output logic [1:0]                           out_gain_pulses,
  output logic [$clog2(WINDOW_DEPTH+1)-1:0]    out_window_fill,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [1:0]                           cfg_data
);

  lcr_pkg::gain_mode_t gain_mode_r;
  lcr_pkg::op_t        push_op, pop_op;
  logic                push, push_ready, pop, pop_valid;

  // gain register: writes are always taken, the reserved code leaves it as is
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_mode_r <= lcr_pkg::GAIN_A128;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_data == lcr_pkg::GAIN_A128 || cfg_data == lcr_pkg::GAIN_A64 ||
          cfg_data == lcr_pkg::GAIN_B32) begin
        gain_mode_r <= lcr_pkg::gain_mode_t'(cfg_data);
      end
    end
  end

  lcr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_data_bit   (in_data_bit),
    .in_tare_value (in_tare_value),
    .push          (push),
    .push_op       (push_op),
    .push_ready    (push_ready)
  );

  lcr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_op    (push_op),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_op     (pop_op)
  );

  lcr_back #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .op_valid          (pop_valid),
    .op                (pop_op),
    .op_pop            (pop),
    .gain_mode         (gain_mode_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sample_value  (out_sample_value),
    .out_average_value (out_average_value),
    .out_net_sample    (out_net_sample),
    .out_net_average   (out_net_average),
    .out_gain_pulses   (out_gain_pulses),
    .out_window_fill   (out_window_fill)
  );

endmodule

// ===== hdl/lcr_checker.sv =====
// Port-level checks for the load-cell reader, bound to the top level.
module lcr_checker #(
  parameter int WINDOW_DEPTH = 16
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [lcr_pkg::WORD_BITS-1:0] out_sample_value,
  input logic signed [lcr_pkg::WORD_BITS-1:0] out_average_value,
  input logic [1:0]                           out_gain_pulses,
  input logic [$clog2(WINDOW_DEPTH+1)-1:0]    out_window_fill
);

  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);

  a_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample_value))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_window_fill == FILL_W'(1) |-> out_average_value == out_sample_value)
    else $error("average of one sample differs from it");

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_window_fill != '0 && out_window_fill <= FILL_W'(WINDOW_DEPTH))
    else $error("window fill out of range");

  a_pulses: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_gain_pulses != 2'd0)
    else $error("zero gain pulses");

endmodule

bind load_cell_adc_serial_reader lcr_checker #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_lcr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_sample_value  (out_sample_value),
  .out_average_value (out_average_value),
  .out_gain_pulses   (out_gain_pulses),
  .out_window_fill   (out_window_fill)
);

// ===== tb/load_cell_adc_serial_reader_tb.sv =====
// Self-checking testbench for the load-cell converter serial reader.
module load_cell_adc_serial_reader_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORD_BITS      = lcr_pkg::WORD_BITS;
  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 11;
  localparam int WINDOW_DEPTH   = 16;
  localparam int FILL_W         = $clog2(WINDOW_DEPTH + 1);
  localparam int SETTLE_CYCLES  = 64;    // time for the back end to finish a sample
  localparam int QUIET_LIMIT    = 2000;  // cycles with no transaction at all
  localparam int ITEMS_PER_PHASE = 240;
  localparam int NUM_PHASES     = 4;

  // command code the package leaves unnamed; the block drops it
  localparam logic [1:0] CMD_RESERVED  = 2'd3;
  // gain code with no meaning; a write of it leaves the mode alone
  localparam logic [1:0] GAIN_RESERVED = 2'd3;

  typedef struct {
    logic [WORD_BITS-1:0] sample;
    logic [WORD_BITS-1:0] average;
    logic [WORD_BITS:0]   net_sample;
    logic [WORD_BITS:0]   net_average;
    logic [1:0]           pulses;
    logic [FILL_W-1:0]    fill;
  } reading_t;

  // Tracks the reader's state transaction by transaction and holds the
  // readings it ought to produce, oldest first.
  class reading_board;
    logic [WORD_BITS-1:0]        shift_reg;
    int unsigned                 bits_in;
    logic signed [WORD_BITS-1:0] ring [WINDOW_DEPTH];
    int unsigned                 slot;
    int unsigned                 fill;
    longint                      sum;
    logic signed [WORD_BITS-1:0] tare;
    lcr_pkg::gain_mode_t         gain;
    reading_t                    expected_q [$];
    int                          mismatch_count;
    int unsigned                 made;

    function new();
      shift_reg      = '0;
      bits_in        = 0;
      slot           = 0;
      fill           = 0;
      sum            = 0;
      tare           = '0;
      gain           = lcr_pkg::GAIN_A128;
      mismatch_count = 0;
      made           = 0;
    endfunction

    // truncated mean of the window, zero while it is empty
    function logic signed [WORD_BITS-1:0] mean();
      if (fill == 0) return '0;
      return WORD_BITS'(sum / longint'(fill));
    endfunction

    function void set_gain(logic [1:0] code);
      if (code != GAIN_RESERVED) gain = lcr_pkg::gain_mode_t'(code);
    endfunction

    function void note_transaction(logic [1:0] cmd, logic dbit,
                                   logic signed [WORD_BITS-1:0] tare_in);
      logic signed [WORD_BITS-1:0] s;
      logic signed [WORD_BITS-1:0] avg;
      reading_t                    r;
      case (cmd)
        lcr_pkg::CMD_CAPTURE: tare = mean();
        lcr_pkg::CMD_LOAD:    tare = tare_in;
        lcr_pkg::CMD_BIT: begin
          shift_reg = {shift_reg[WORD_BITS-2:0], dbit};
          bits_in++;
          if (bits_in == WORD_BITS) begin
            s         = shift_reg;
            shift_reg = '0;
            bits_in   = 0;
            // full ring: the oldest entry drops out of the sum
            if (fill == WINDOW_DEPTH) sum -= ring[slot];
            else fill++;
            ring[slot] = s;
            sum       += s;
            slot       = (slot + 1) % WINDOW_DEPTH;
            avg        = mean();
            r.sample      = s;
            r.average     = avg;
            r.net_sample  = (WORD_BITS+1)'(longint'(s) - longint'(tare));
            r.net_average = (WORD_BITS+1)'(longint'(avg) - longint'(tare));
            case (gain)
              lcr_pkg::GAIN_A64: r.pulses = lcr_pkg::PULSES_A64;
              lcr_pkg::GAIN_B32: r.pulses = lcr_pkg::PULSES_B32;
              default:           r.pulses = lcr_pkg::PULSES_A128;
            endcase
            r.fill = FILL_W'(fill);
            expected_q = {expected_q, r};
            made++;
          end
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH %s", $realtime, msg);
      mismatch_count++;
    endtask

    task check_reading(reading_t got);
      reading_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result, sample %h", got.sample));
        return;
      end
      want = expected_q.pop_front();
      if (got.sample !== want.sample)
        report_mismatch($sformatf("sample_value %h, want %h", got.sample, want.sample));
      if (got.average !== want.average)
        report_mismatch($sformatf("average_value %h, want %h", got.average, want.average));
      if (got.net_sample !== want.net_sample)
        report_mismatch($sformatf("net_sample %h, want %h",
                                  got.net_sample, want.net_sample));
      if (got.net_average !== want.net_average)
        report_mismatch($sformatf("net_average %h, want %h",
                                  got.net_average, want.net_average));
      if (got.pulses !== want.pulses)
        report_mismatch($sformatf("gain_pulses %0d, want %0d", got.pulses, want.pulses));
      if (got.fill !== want.fill)
        report_mismatch($sformatf("window_fill %0d, want %0d", got.fill, want.fill));
    endtask
  endclass

  // ---------------------------------------------------------------------
  // Clock, reset and DUT signals; every input is known from time zero
  // ---------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                        in_valid      = 1'b0;
  logic                        in_stall;
  logic [1:0]                  in_cmd        = lcr_pkg::CMD_BIT;
  logic                        in_data_bit   = 1'b0;
  logic signed [WORD_BITS-1:0] in_tare_value = '0;
  logic                        out_valid;
  logic                        out_stall     = 1'b0;
  logic signed [WORD_BITS-1:0] out_sample_value;
  logic signed [WORD_BITS-1:0] out_average_value;
  logic signed [WORD_BITS:0]   out_net_sample;
  logic signed [WORD_BITS:0]   out_net_average;
  logic [1:0]                  out_gain_pulses;
  logic [FILL_W-1:0]           out_window_fill;
  logic                        cfg_valid     = 1'b0;
  logic                        cfg_ready;
  logic [1:0]                  cfg_data      = '0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  load_cell_adc_serial_reader #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_data_bit      (in_data_bit),
    .in_tare_value    (in_tare_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample_value (out_sample_value),
    .out_average_value(out_average_value),
    .out_net_sample   (out_net_sample),
    .out_net_average  (out_net_average),
    .out_gain_pulses  (out_gain_pulses),
    .out_window_fill  (out_window_fill),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  reading_board board = new();

  // idling odds in percent, set per phase by the stimulus process
  int idle_pct  = 0;
  int stall_pct = 0;
  int unsigned items_sent = 0;   // reserved commands not counted

  // ---------------------------------------------------------------------
  // Result side. Handshake values are read straight after the edge, i.e.
  // before any NBA of that step lands, so they are the ones the edge saw.
  // The stall for the next cycle is drawn afresh every edge.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_reading('{out_sample_value, out_average_value, out_net_sample,
                            out_net_average, out_gain_pulses, out_window_fill});
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------------
  // Watchdog: any accepted transaction on any channel resets the count
  // ---------------------------------------------------------------------
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Sender tasks
  // ---------------------------------------------------------------------

  // One input transaction, with random idle cycles ahead of it. After the
  // accepting edge nothing is assigned, so the next call (or a drain) owns
  // the single NBA to in_valid in that step.
  task automatic push_item(logic [1:0] cmd, logic dbit, logic [WORD_BITS-1:0] tare_in);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_data_bit   <= dbit;
    in_tare_value <= tare_in;
    do @(posedge clk); while (in_stall);
    board.note_transaction(cmd, dbit, tare_in);
    if (cmd != CMD_RESERVED) items_sent++;
  endtask

  // Field value leaning on the extremes of a signed 24-bit word
  function automatic logic [WORD_BITS-1:0] pick_value();
    case ($urandom_range(5))
      0:       return 24'h800000;
      1:       return 24'h7FFFFF;
      2:       return '0;
      3:       return '1;
      default: return WORD_BITS'($urandom());
    endcase
  endfunction

  // Tare commands and dropped codes; none of them should disturb shifting
  task automatic push_noise();
    case ($urandom_range(2))
      0:       push_item(lcr_pkg::CMD_CAPTURE, 1'($urandom()), WORD_BITS'($urandom()));
      1:       push_item(lcr_pkg::CMD_LOAD, 1'($urandom()), pick_value());
      default: push_item(CMD_RESERVED, 1'($urandom()), WORD_BITS'($urandom()));
    endcase
  endtask

  // A full conversion, MSB first; when noisy, tare commands and dropped
  // codes now and then land between bits
  task automatic push_word(logic [WORD_BITS-1:0] word, bit noisy);
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (noisy && $urandom_range(39) == 0) push_noise();
      push_item(lcr_pkg::CMD_BIT, word[i], WORD_BITS'($urandom()));
    end
  endtask

  // Sender holds off until every predicted reading has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.expected_q.size() != 0) @(posedge clk);
  endtask

  // Drained plus the back end's latency, so the block is truly idle
  task automatic settle();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_gain(logic [1:0] code);
    cfg_valid <= 1'b1;
    cfg_data  <= code;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.set_gain(code);
  endtask

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin
    // per phase: sender idle %, receiver stall %, gain code written first.
    // The reserved code in phase 1 must leave channel B gain 32 in force.
    int unsigned      phase_idle  [NUM_PHASES] = '{0, 65, 0, 36};
    int unsigned      phase_stall [NUM_PHASES] = '{0, 0, 65, 36};
    logic [1:0]       phase_gain  [NUM_PHASES] = '{lcr_pkg::GAIN_B32, GAIN_RESERVED,
                                                   lcr_pkg::GAIN_A64, lcr_pkg::GAIN_A128};
    int unsigned      goal;
    int unsigned      tail;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, at the reset gain mode:
    // capture on an empty window gives a zero tare, both tare extremes are
    // loaded, a dropped code carries live-looking data, then the most
    // negative sample against the most positive tare gives the lowest net
    // value, and a capture takes a full-scale negative average as tare.
    push_item(lcr_pkg::CMD_CAPTURE, 1'b1, 24'h7FFFFF);
    push_item(lcr_pkg::CMD_LOAD, 1'b0, 24'h800000);
    push_item(CMD_RESERVED, 1'b1, 24'h7FFFFF);
    push_item(lcr_pkg::CMD_LOAD, 1'b1, 24'h7FFFFF);
    push_word(24'h800000, 1'b0);
    push_item(lcr_pkg::CMD_CAPTURE, 1'b0, '0);

    goal = 0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      // gain is only written with the back end empty
      settle();
      write_gain(phase_gain[p]);
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      goal     += ITEMS_PER_PHASE;
      while (items_sent < goal) begin
        // occasional mid-phase pause until the result side catches up
        if ($urandom_range(59) == 0) drain_results();
        if ($urandom_range(99) < 85) begin
          push_word(pick_value(), 1'b1);
        end else begin
          case ($urandom_range(2))
            0: push_noise();
            1: push_item(lcr_pkg::CMD_BIT, 1'($urandom()), WORD_BITS'($urandom()));
            default: begin
              // short burst of bits that shifts the word framing
              tail = $urandom_range(1, WORD_BITS - 1);
              repeat (tail)
                push_item(lcr_pkg::CMD_BIT, 1'($urandom()), WORD_BITS'($urandom()));
            end
          endcase
        end
      end
    end

    settle();
    if (board.mismatch_count == 0 && board.expected_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
